FILE: rtl/core/led_strip_double_buffer_serializer_core_defines.svh
// assertion helpers for the led strip serializer core
`ifndef LED_STRIP_DOUBLE_BUFFER_SERIALIZER_CORE_DEFINES_SVH
`define LED_STRIP_DOUBLE_BUFFER_SERIALIZER_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define LSDBS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LSDBS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/lsdbs_pkg.sv
`default_nettype none
package lsdbs_pkg;

    localparam int MAX_PIXELS_DEF = 256;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 8;
    localparam int COLOR_W = 32;
    localparam int PCNT_W  = 9;
    localparam int ORDER_W = 8;
    localparam int TICK_W  = 15;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 15;

    localparam logic [PCNT_W-1:0]  PIXEL_COUNT_RST   = 9'd256;
    localparam logic [ORDER_W-1:0] CHANNEL_ORDER_RST = 8'd82;
    localparam logic [TICK_W-1:0]  ONE_HIGH_RST      = 15'd9;
    localparam logic [TICK_W-1:0]  ONE_LOW_RST       = 15'd3;
    localparam logic [TICK_W-1:0]  ZERO_HIGH_RST     = 15'd3;
    localparam logic [TICK_W-1:0]  ZERO_LOW_RST      = 15'd9;

    localparam logic [OP_W-1:0] OP_SET_PIXEL  = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR      = 2'd1;
    localparam logic [OP_W-1:0] OP_SHOW       = 2'd2;
    localparam logic [OP_W-1:0] OP_SEND_PIXEL = 2'd3;

    localparam logic [CFG_IW-1:0] REG_PIXEL_COUNT   = 3'd0;
    localparam logic [CFG_IW-1:0] REG_CHANNEL_ORDER = 3'd1;
    localparam logic [CFG_IW-1:0] REG_CLEAR_ON_SHOW = 3'd2;
    localparam logic [CFG_IW-1:0] REG_ONE_HIGH      = 3'd3;
    localparam logic [CFG_IW-1:0] REG_ONE_LOW       = 3'd4;
    localparam logic [CFG_IW-1:0] REG_ZERO_HIGH     = 3'd5;
    localparam logic [CFG_IW-1:0] REG_ZERO_LOW      = 3'd6;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;
    localparam logic [1:0] CH_WHITE = 2'd3;

    typedef struct packed {
        logic [PCNT_W-1:0]  pixel_count;
        logic [ORDER_W-1:0] channel_order;
        logic               clear_on_show;
        logic [TICK_W-1:0]  one_high;
        logic [TICK_W-1:0]  one_low;
        logic [TICK_W-1:0]  zero_high;
        logic [TICK_W-1:0]  zero_low;
    } t_cfg;

    typedef struct packed {
        logic set_wr;
        logic toggle_front;
        logic send_rd;
        logic sweep_start;
        logic sweep_show;
        logic sweep_run;
        logic init_run;
        logic load_word;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic idx_ok;
        logic init_done;
        logic sweep_done;
        logic last_bit;
    } t_status;

    function automatic logic [7:0] pick_byte(input logic [COLOR_W-1:0] color,
                                             input logic [1:0] sel);
        logic [7:0] b;
        case (sel)
            CH_RED:   b = color[23:16];
            CH_GREEN: b = color[15:8];
            CH_BLUE:  b = color[7:0];
            CH_WHITE: b = color[31:24];
            default:  b = color[31:24];
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lsdbs_ram.sv
`default_nettype none
module lsdbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/core/lsdbs_ctrl.sv
`default_nettype none
module lsdbs_ctrl
    import lsdbs_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire logic [OP_W-1:0] i_opcode,
    input  wire t_status         i_status,
    output logic                 o_busy,
    output t_cmd                 o_cmd
);

    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_SWEEP = 3'd2;
    localparam logic [2:0] S_LOAD  = 3'd3;
    localparam logic [2:0] S_SEND  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_INIT: begin
                o_cmd.init_run = 1'b1;
                if (i_status.init_done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    case (i_opcode)
                        OP_SET_PIXEL: begin
                            o_cmd.set_wr = i_status.idx_ok;
                        end
                        OP_CLEAR: begin
                            o_cmd.sweep_start = 1'b1;
                            n_state           = S_SWEEP;
                        end
                        OP_SHOW: begin
                            o_cmd.toggle_front = 1'b1;
                            o_cmd.sweep_start  = 1'b1;
                            o_cmd.sweep_show   = 1'b1;
                            n_state            = S_SWEEP;
                        end
                        OP_SEND_PIXEL: begin
                            if (i_status.idx_ok) begin
                                o_cmd.send_rd = 1'b1;
                                n_state       = S_LOAD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SWEEP: begin
                o_cmd.sweep_run = 1'b1;
                if (i_status.sweep_done) begin
                    n_state = S_IDLE;
                end
            end
            S_LOAD: begin
                o_cmd.load_word = 1'b1;
                n_state         = S_SEND;
            end
            S_SEND: begin
                o_cmd.emit = 1'b1;
                if (i_status.last_bit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule
`default_nettype wire

FILE: rtl/core/lsdbs_datapath.sv
`default_nettype none
module lsdbs_datapath
    import lsdbs_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cfg               i_cfg,
    input  wire t_cmd               i_cmd,
    input  wire logic [IDX_W-1:0]   i_pixel_index,
    input  wire logic [COLOR_W-1:0] i_pixel_color,
    output t_status                 o_status,
    output logic                    o_strobe,
    output logic [TICK_W-1:0]       o_pulse_high_ticks,
    output logic [TICK_W-1:0]       o_pulse_low_ticks,
    output logic                    o_data_bit,
    output logic                    o_last_pulse
);

    localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int CW = $clog2(MAX_PIXELS + 1);
    localparam int UW = (CW > PCNT_W) ? CW : PCNT_W;

    logic             r_front_a;
    logic [UW-1:0]    r_cnt;
    logic             r_clr;
    logic             r_wr_pend;
    logic [AW-1:0]    r_wr_addr;
    logic [COLOR_W-1:0] r_word;
    logic [1:0]       r_ch;
    logic [2:0]       r_bit;

    logic [UW-1:0]    used;
    logic [UW-1:0]    pc_ext;
    logic [UW-1:0]    max_c;
    logic             cnt_lt;
    logic [AW-1:0]    cnt_a;
    logic [AW-1:0]    idx_a;

    logic             we_back;
    logic [AW-1:0]    wa_back;
    logic [COLOR_W-1:0] wd_back;
    logic             init_wr;
    logic             we_a, we_b;
    logic [AW-1:0]    wa_a, wa_b, raddr;
    logic [COLOR_W-1:0] wd_a, wd_b, rd_a, rd_b, front_rd;

    logic [1:0]       sel;
    logic [1:0]       last_ch;
    logic [7:0]       cur_byte;
    logic             cur_bit;
    logic             last;

    assign pc_ext = UW'(i_cfg.pixel_count);
    assign max_c  = UW'(MAX_PIXELS);
    assign used   = (pc_ext > max_c) ? max_c : pc_ext;
    assign cnt_lt = (r_cnt < used);
    assign cnt_a  = r_cnt[AW-1:0];
    assign idx_a  = AW'(i_pixel_index);

    assign o_status.idx_ok     = (UW'(i_pixel_index) < used);
    assign o_status.init_done  = (r_cnt == max_c);
    assign o_status.sweep_done = !cnt_lt && !r_wr_pend;
    assign o_status.last_bit   = last;

    // back buffer writes: set pixel, clear sweep, or the delayed half of a copy
    always_comb begin
        we_back = 1'b0;
        wa_back = idx_a;
        wd_back = i_pixel_color;
        if (i_cmd.set_wr) begin
            we_back = 1'b1;
        end else if (i_cmd.sweep_run && r_clr) begin
            we_back = cnt_lt;
            wa_back = cnt_a;
            wd_back = '0;
        end else if (i_cmd.sweep_run && r_wr_pend) begin
            we_back = 1'b1;
            wa_back = r_wr_addr;
            wd_back = front_rd;
        end
    end

    assign init_wr = i_cmd.init_run && !o_status.init_done;
    assign we_a    = init_wr || (we_back && !r_front_a);
    assign we_b    = init_wr || (we_back && r_front_a);
    assign wa_a    = init_wr ? cnt_a : wa_back;
    assign wa_b    = init_wr ? cnt_a : wa_back;
    assign wd_a    = init_wr ? '0 : wd_back;
    assign wd_b    = init_wr ? '0 : wd_back;
    assign raddr   = i_cmd.send_rd ? idx_a : cnt_a;
    assign front_rd = r_front_a ? rd_a : rd_b;

    lsdbs_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_PIXELS)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (we_a),
        .i_waddr (wa_a),
        .i_wdata (wd_a),
        .i_raddr (raddr),
        .o_rdata (rd_a)
    );

    lsdbs_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_PIXELS)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (we_b),
        .i_waddr (wa_b),
        .i_wdata (wd_b),
        .i_raddr (raddr),
        .o_rdata (rd_b)
    );

    // channel selectors: first 5:4, second 3:2, third 1:0, fourth 7:6
    always_comb begin
        case (r_ch)
            2'd0:    sel = i_cfg.channel_order[5:4];
            2'd1:    sel = i_cfg.channel_order[3:2];
            2'd2:    sel = i_cfg.channel_order[1:0];
            default: sel = i_cfg.channel_order[7:6];
        endcase
    end

    assign last_ch  = (i_cfg.channel_order[7:6] != i_cfg.channel_order[5:4]) ? 2'd3 : 2'd2;
    assign cur_byte = pick_byte(r_word, sel);
    assign cur_bit  = cur_byte[r_bit];
    assign last     = (r_ch == last_ch) && (r_bit == 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_a <= 1'b0;
            r_cnt     <= '0;
            r_wr_pend <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            if (i_cmd.toggle_front) begin
                r_front_a <= !r_front_a;
            end
            if (i_cmd.sweep_start) begin
                r_cnt <= '0;
            end else if ((i_cmd.sweep_run && cnt_lt) || init_wr) begin
                r_cnt <= r_cnt + 1'b1;
            end
            r_wr_pend <= i_cmd.sweep_run && !r_clr && cnt_lt;
            o_strobe  <= i_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep_start) begin
            r_clr <= i_cmd.sweep_show ? i_cfg.clear_on_show : 1'b1;
        end
        r_wr_addr <= cnt_a;
        if (i_cmd.load_word) begin
            r_word <= front_rd;
            r_ch   <= 2'd0;
            r_bit  <= 3'd7;
        end else if (i_cmd.emit) begin
            if (r_bit == 3'd0) begin
                r_ch <= r_ch + 2'd1;
            end
            r_bit <= r_bit - 3'd1;
        end
        if (i_cmd.emit) begin
            o_pulse_high_ticks <= cur_bit ? i_cfg.one_high : i_cfg.zero_high;
            o_pulse_low_ticks  <= cur_bit ? i_cfg.one_low : i_cfg.zero_low;
            o_data_bit         <= cur_bit;
            o_last_pulse       <= last;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/led_strip_double_buffer_serializer_core.sv
// channel   | direction | handshake                | beat
// ----------+-----------+--------------------------+---------------------------------------
// command   | in        | start & !busy            | opcode, pixel_index, pixel_color
// result    | out       | o_strobe, one cycle      | pulse high/low ticks, data bit, last
// config    | in        | i_cfg_we, no wait        | i_cfg_index, i_cfg_data
//
// set pixel writes the back store directly; clear and show each run a sweep of the back
// store, one entry a cycle, that clears it, or that copies the front store into it for a
// show without clear (the copy reading one store and writing the other); send pixel does
// a store read and a load, then one pulse beat per cycle, 24 or 32 beats back to back.
// after reset a clearing pass zeroes both stores while busy is high. results cannot be
// stalled.
`default_nettype none
`include "led_strip_double_buffer_serializer_core_defines.svh"
module led_strip_double_buffer_serializer_core
    import lsdbs_pkg::*;
#(
    parameter int MAX_PIXELS = MAX_PIXELS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [OP_W-1:0]    i_opcode,
    input  wire logic [IDX_W-1:0]   i_pixel_index,
    input  wire logic [COLOR_W-1:0] i_pixel_color,
    input  wire logic               i_cfg_we,
    input  wire logic [CFG_IW-1:0]  i_cfg_index,
    input  wire logic [CFG_DW-1:0]  i_cfg_data,
    output logic                    o_strobe,
    output logic [TICK_W-1:0]       o_pulse_high_ticks,
    output logic [TICK_W-1:0]       o_pulse_low_ticks,
    output logic                    o_data_bit,
    output logic                    o_last_pulse
);

    t_cfg    r_cfg;
    t_cmd    cmd;
    t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pixel_count   <= PIXEL_COUNT_RST;
            r_cfg.channel_order <= CHANNEL_ORDER_RST;
            r_cfg.clear_on_show <= 1'b0;
            r_cfg.one_high      <= ONE_HIGH_RST;
            r_cfg.one_low       <= ONE_LOW_RST;
            r_cfg.zero_high     <= ZERO_HIGH_RST;
            r_cfg.zero_low      <= ZERO_LOW_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_PIXEL_COUNT:   r_cfg.pixel_count   <= i_cfg_data[PCNT_W-1:0];
                REG_CHANNEL_ORDER: r_cfg.channel_order <= i_cfg_data[ORDER_W-1:0];
                REG_CLEAR_ON_SHOW: r_cfg.clear_on_show <= i_cfg_data[0];
                REG_ONE_HIGH:      r_cfg.one_high      <= i_cfg_data[TICK_W-1:0];
                REG_ONE_LOW:       r_cfg.one_low       <= i_cfg_data[TICK_W-1:0];
                REG_ZERO_HIGH:     r_cfg.zero_high     <= i_cfg_data[TICK_W-1:0];
                REG_ZERO_LOW:      r_cfg.zero_low      <= i_cfg_data[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    lsdbs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_opcode (i_opcode),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    lsdbs_datapath #(.MAX_PIXELS(MAX_PIXELS)) u_datapath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg              (r_cfg),
        .i_cmd              (cmd),
        .i_pixel_index      (i_pixel_index),
        .i_pixel_color      (i_pixel_color),
        .o_status           (status),
        .o_strobe           (o_strobe),
        .o_pulse_high_ticks (o_pulse_high_ticks),
        .o_pulse_low_ticks  (o_pulse_low_ticks),
        .o_data_bit         (o_data_bit),
        .o_last_pulse       (o_last_pulse)
    );

    // a beat always comes out of a send that held busy the cycle before
    `LSDBS_ASSERT_IMPL(a_strobe_while_busy, o_strobe, $past(busy), "beat without busy")
    // beats of one pixel come back to back
    `LSDBS_ASSERT_NEXT(a_beats_contiguous, o_strobe && !o_last_pulse, o_strobe, "gap in pixel")
    // the next pixel needs a store read first, so a gap follows the last beat
    `LSDBS_ASSERT_NEXT(a_gap_after_last, o_strobe && o_last_pulse, !o_strobe, "no gap after last")

endmodule
`default_nettype wire
